// File: rtl/bls_pkg.sv
// Shared widths, types and register codes for the battery level smoother.
package bls_pkg;

   localparam int ADC_W      = 12;
   localparam int GAIN_W     = 24;
   localparam int ALPHA_W    = 9;
   localparam int MV_W       = 16;
   localparam int PCT_W      = 7;
   localparam int MV_FRAC    = 16;
   localparam int PROD_W     = ADC_W + GAIN_W;
   localparam int EMA_W      = MV_W + ALPHA_W;
   localparam int EMA_FRAC   = 8;
   localparam int DIV_W      = 24;
   localparam int DSH_W      = MV_W + PCT_W;
   localparam int CSR_IDX_W  = 2;
   localparam int CSR_DATA_W = 24;

   typedef logic [ADC_W-1:0]      raw_type;
   typedef logic [GAIN_W-1:0]     gain_type;
   typedef logic [ALPHA_W-1:0]    alpha_type;
   typedef logic [MV_W-1:0]       mv_type;
   typedef logic [PCT_W-1:0]      pct_type;
   typedef logic [CSR_IDX_W-1:0]  csr_idx_type;
   typedef logic [CSR_DATA_W-1:0] csr_data_type;

   localparam csr_idx_type CSR_GAIN  = 2'd0;
   localparam csr_idx_type CSR_ALPHA = 2'd1;
   localparam csr_idx_type CSR_EMPTY = 2'd2;
   localparam csr_idx_type CSR_FULL  = 2'd3;

   localparam gain_type  GAIN_RESET  = 24'd216190;
   localparam alpha_type ALPHA_RESET = 9'd26;
   localparam mv_type    EMPTY_RESET = 16'd9900;
   localparam mv_type    FULL_RESET  = 16'd12600;

   localparam alpha_type ALPHA_ONE = 9'd256;
   localparam pct_type   PCT_FULL  = 7'd100;
   localparam pct_type   PCT_EMPTY = 7'd0;

endpackage

// File: rtl/bls_req_if.sv
// Sample request channel carrying one raw ADC conversion per transaction.
interface bls_req_if;
   import bls_pkg::*;

   logic    valid;
   logic    ready;
   raw_type adc_sample;

   modport source (output valid, output adc_sample, input ready);
   modport sink (input valid, input adc_sample, output ready);

endinterface

// File: rtl/bls_rsp_if.sv
// Result channel carrying the smoothed voltage and charge estimate.
interface bls_rsp_if;
   import bls_pkg::*;

   logic    valid;
   logic    ready;
   mv_type  voltage_mv;
   pct_type charge_percent;

   modport source (output valid, output voltage_mv, output charge_percent, input ready);
   modport sink (input valid, input voltage_mv, input charge_percent, output ready);

endinterface

// File: rtl/bls_scale_mul.sv
// Bit-serial multiplier that scales a raw sample to saturated millivolts.
module bls_scale_mul (
   input  logic             clock,
   input  logic             reset,
   input  logic             start,
   input  bls_pkg::raw_type  raw,
   input  bls_pkg::gain_type gain,
   output logic             done,
   output bls_pkg::mv_type   mv
);
   import bls_pkg::*;

   localparam int CNT_W = $clog2(ADC_W);
   localparam logic [PROD_W-1:0] ROUND_HALF = PROD_W'(1) << (MV_FRAC - 1);

   logic              busy_ff, busy_in;
   logic              done_ff, done_in;
   logic [CNT_W-1:0]  cnt_ff, cnt_in;
   raw_type           raw_ff, raw_in;
   logic [PROD_W-1:0] acc_ff, acc_in;
   logic [PROD_W-1:0] sum;

   always_comb begin
      busy_in = busy_ff;
      done_in = 1'b0;
      cnt_in  = cnt_ff;
      raw_in  = raw_ff;
      acc_in  = acc_ff;
      if (start) begin
         busy_in = 1'b1;
         cnt_in  = CNT_W'(ADC_W - 1);
         raw_in  = raw;
         acc_in  = '0;
      end else if (busy_ff) begin
         acc_in = {acc_ff[PROD_W-2:0], 1'b0}
                  + (raw_ff[ADC_W-1] ? PROD_W'(gain) : {PROD_W{1'b0}});
         raw_in = {raw_ff[ADC_W-2:0], 1'b0};
         cnt_in = cnt_ff - 1'b1;
         if (cnt_ff == '0) begin
            busy_in = 1'b0;
            done_in = 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         done_ff <= 1'b0;
         cnt_ff  <= '0;
      end else begin
         busy_ff <= busy_in;
         done_ff <= done_in;
         cnt_ff  <= cnt_in;
      end
   end

   always_ff @(posedge clock) begin
      raw_ff <= raw_in;
      acc_ff <= acc_in;
   end

   assign sum  = acc_ff + ROUND_HALF;
   assign mv   = (|sum[PROD_W-1:MV_FRAC+MV_W]) ? {MV_W{1'b1}} : sum[MV_FRAC+MV_W-1:MV_FRAC];
   assign done = done_ff;

endmodule

// File: rtl/bls_ema.sv
// Bit-serial moving average that blends the new voltage into the stored one.
module bls_ema (
   input  logic              clock,
   input  logic              reset,
   input  logic              start,
   input  bls_pkg::mv_type    new_mv,
   input  bls_pkg::mv_type    old_mv,
   input  bls_pkg::alpha_type alpha,
   output logic              done,
   output bls_pkg::mv_type    smoothed
);
   import bls_pkg::*;

   localparam int CNT_W = $clog2(ALPHA_W);
   localparam logic [EMA_W-1:0] ROUND_HALF = EMA_W'(1) << (EMA_FRAC - 1);

   logic             busy_ff, busy_in;
   logic             done_ff, done_in;
   logic [CNT_W-1:0] cnt_ff, cnt_in;
   alpha_type        a_ff, a_in;
   alpha_type        b_ff, b_in;
   mv_type           new_ff, new_in;
   mv_type           old_ff, old_in;
   logic             load_ff, load_in;
   logic [EMA_W-1:0] acc_ff, acc_in;
   alpha_type        a_clamp;
   logic [EMA_W-1:0] sum;

   assign a_clamp = alpha[ALPHA_W-1] ? ALPHA_ONE : alpha;

   always_comb begin
      busy_in = busy_ff;
      done_in = 1'b0;
      cnt_in  = cnt_ff;
      a_in    = a_ff;
      b_in    = b_ff;
      new_in  = new_ff;
      old_in  = old_ff;
      load_in = load_ff;
      acc_in  = acc_ff;
      if (start) begin
         busy_in = 1'b1;
         cnt_in  = CNT_W'(ALPHA_W - 1);
         a_in    = a_clamp;
         b_in    = ALPHA_ONE - a_clamp;
         new_in  = new_mv;
         old_in  = old_mv;
         load_in = (old_mv == '0);
         acc_in  = '0;
      end else if (busy_ff) begin
         acc_in = {acc_ff[EMA_W-2:0], 1'b0}
                  + (a_ff[ALPHA_W-1] ? EMA_W'(new_ff) : {EMA_W{1'b0}})
                  + (b_ff[ALPHA_W-1] ? EMA_W'(old_ff) : {EMA_W{1'b0}});
         a_in   = {a_ff[ALPHA_W-2:0], 1'b0};
         b_in   = {b_ff[ALPHA_W-2:0], 1'b0};
         cnt_in = cnt_ff - 1'b1;
         if (cnt_ff == '0) begin
            busy_in = 1'b0;
            done_in = 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         done_ff <= 1'b0;
         cnt_ff  <= '0;
      end else begin
         busy_ff <= busy_in;
         done_ff <= done_in;
         cnt_ff  <= cnt_in;
      end
   end

   always_ff @(posedge clock) begin
      a_ff    <= a_in;
      b_ff    <= b_in;
      new_ff  <= new_in;
      old_ff  <= old_in;
      load_ff <= load_in;
      acc_ff  <= acc_in;
   end

   assign sum      = acc_ff + ROUND_HALF;
   assign smoothed = load_ff ? new_ff : sum[EMA_FRAC+MV_W-1:EMA_FRAC];
   assign done     = done_ff;

endmodule

// File: rtl/bls_pct_div.sv
// Restoring serial divider that maps a voltage to a rounded percentage.
module bls_pct_div (
   input  logic           clock,
   input  logic           reset,
   input  logic           start,
   input  bls_pkg::mv_type v,
   input  bls_pkg::mv_type empty_mv,
   input  bls_pkg::mv_type full_mv,
   output logic           done,
   output bls_pkg::pct_type percent
);
   import bls_pkg::*;

   localparam int CNT_W = $clog2(PCT_W);

   logic             prep_ff, prep_in;
   logic             busy_ff, busy_in;
   logic             done_ff, done_in;
   logic [CNT_W-1:0] cnt_ff, cnt_in;
   mv_type           diff_ff, diff_in;
   mv_type           span_ff, span_in;
   logic             forced_ff, forced_in;
   pct_type          fval_ff, fval_in;
   logic [DIV_W-1:0] rem_ff, rem_in;
   logic [DSH_W-1:0] dsh_ff, dsh_in;
   pct_type          q_ff, q_in;
   logic             ge;

   assign ge = rem_ff >= {1'b0, dsh_ff};

   always_comb begin
      prep_in   = 1'b0;
      busy_in   = busy_ff;
      done_in   = 1'b0;
      cnt_in    = cnt_ff;
      diff_in   = diff_ff;
      span_in   = span_ff;
      forced_in = forced_ff;
      fval_in   = fval_ff;
      rem_in    = rem_ff;
      dsh_in    = dsh_ff;
      q_in      = q_ff;
      if (start) begin
         prep_in   = 1'b1;
         diff_in   = v - empty_mv;
         span_in   = full_mv - empty_mv;
         forced_in = (full_mv <= empty_mv) || (v <= empty_mv) || (v >= full_mv);
         fval_in   = ((full_mv > empty_mv) && (v >= full_mv)) ? PCT_FULL : PCT_EMPTY;
      end else if (prep_ff) begin
         busy_in = 1'b1;
         cnt_in  = CNT_W'(PCT_W - 1);
         rem_in  = {1'b0, diff_ff, 7'b0} + {2'b0, diff_ff, 6'b0}
                   + {5'b0, diff_ff, 3'b0} + {8'b0, span_ff};
         dsh_in  = {span_ff, 7'b0};
         q_in    = '0;
      end else if (busy_ff) begin
         rem_in = ge ? rem_ff - {1'b0, dsh_ff} : rem_ff;
         q_in   = {q_ff[PCT_W-2:0], ge};
         dsh_in = {1'b0, dsh_ff[DSH_W-1:1]};
         cnt_in = cnt_ff - 1'b1;
         if (cnt_ff == '0) begin
            busy_in = 1'b0;
            done_in = 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         prep_ff <= 1'b0;
         busy_ff <= 1'b0;
         done_ff <= 1'b0;
         cnt_ff  <= '0;
      end else begin
         prep_ff <= prep_in;
         busy_ff <= busy_in;
         done_ff <= done_in;
         cnt_ff  <= cnt_in;
      end
   end

   always_ff @(posedge clock) begin
      diff_ff   <= diff_in;
      span_ff   <= span_in;
      forced_ff <= forced_in;
      fval_ff   <= fval_in;
      rem_ff    <= rem_in;
      dsh_ff    <= dsh_in;
      q_ff      <= q_in;
   end

   assign percent = forced_ff ? fval_ff : q_ff;
   assign done    = done_ff;

endmodule

// File: rtl/battery_level_smoother.sv
// Top level of the battery level smoother: sequencer, registers and result stage.
// From sample acceptance to a valid result a sample passes 12 multiply steps,
// 9 averaging steps, a divider setup step, 7 divide steps and the handoffs between units.
// Samples are accepted only while idle; one waiting result does not block acceptance.
// Synchronous reset restores the default calibration and clears the smoothed voltage.
module battery_level_smoother #(
   parameter int unsigned ADC_BITS = 12
) (
   input  logic                  clock,
   input  logic                  reset,
   bls_req_if.sink               req_ch,
   bls_rsp_if.source             rsp_ch,
   input  logic                  csr_wr_en,
   input  bls_pkg::csr_idx_type  csr_index,
   input  bls_pkg::csr_data_type csr_wdata
);
   import bls_pkg::*;

   localparam int unsigned RAW_BITS = (ADC_BITS < ADC_W) ? ADC_BITS : ADC_W;
   localparam raw_type RAW_MASK = ADC_W'((64'd1 << RAW_BITS) - 64'd1);

   localparam logic [2:0] S_IDLE = 3'd0;
   localparam logic [2:0] S_MUL  = 3'd1;
   localparam logic [2:0] S_EMA  = 3'd2;
   localparam logic [2:0] S_DIV  = 3'd3;
   localparam logic [2:0] S_OUT  = 3'd4;

   logic [2:0] state_ff, state_in;
   gain_type   gain_ff, gain_in;
   alpha_type  alpha_ff, alpha_in;
   mv_type     empty_ff, empty_in;
   mv_type     full_ff, full_in;
   mv_type     smoothed_ff, smoothed_in;
   logic       rsp_valid_ff, rsp_valid_in;
   mv_type     rsp_mv_ff, rsp_mv_in;
   pct_type    rsp_pct_ff, rsp_pct_in;

   logic    req_take;
   logic    mul_done, ema_done, div_done;
   mv_type  new_mv, ema_mv;
   pct_type pct;

   assign req_take = req_ch.valid && req_ch.ready;

   bls_scale_mul u_mul (
      .clock (clock),
      .reset (reset),
      .start (req_take),
      .raw   (req_ch.adc_sample & RAW_MASK),
      .gain  (gain_ff),
      .done  (mul_done),
      .mv    (new_mv)
   );

   bls_ema u_ema (
      .clock    (clock),
      .reset    (reset),
      .start    (mul_done),
      .new_mv   (new_mv),
      .old_mv   (smoothed_ff),
      .alpha    (alpha_ff),
      .done     (ema_done),
      .smoothed (ema_mv)
   );

   bls_pct_div u_div (
      .clock    (clock),
      .reset    (reset),
      .start    (ema_done),
      .v        (ema_mv),
      .empty_mv (empty_ff),
      .full_mv  (full_ff),
      .done     (div_done),
      .percent  (pct)
   );

   always_comb begin
      gain_in  = gain_ff;
      alpha_in = alpha_ff;
      empty_in = empty_ff;
      full_in  = full_ff;
      if (csr_wr_en) begin
         case (csr_index)
            CSR_GAIN:  gain_in  = csr_wdata[GAIN_W-1:0];
            CSR_ALPHA: alpha_in = csr_wdata[ALPHA_W-1:0];
            CSR_EMPTY: empty_in = csr_wdata[MV_W-1:0];
            CSR_FULL:  full_in  = csr_wdata[MV_W-1:0];
            default: begin
            end
         endcase
      end
   end

   always_comb begin
      state_in     = state_ff;
      smoothed_in  = smoothed_ff;
      rsp_valid_in = rsp_valid_ff && !rsp_ch.ready;
      rsp_mv_in    = rsp_mv_ff;
      rsp_pct_in   = rsp_pct_ff;
      case (state_ff)
         S_IDLE: begin
            if (req_take) begin
               state_in = S_MUL;
            end
         end
         S_MUL: begin
            if (mul_done) begin
               state_in = S_EMA;
            end
         end
         S_EMA: begin
            if (ema_done) begin
               smoothed_in = ema_mv;
               state_in    = S_DIV;
            end
         end
         S_DIV: begin
            if (div_done) begin
               state_in = S_OUT;
            end
         end
         S_OUT: begin
            if (!rsp_valid_ff || rsp_ch.ready) begin
               rsp_valid_in = 1'b1;
               rsp_mv_in    = smoothed_ff;
               rsp_pct_in   = pct;
               state_in     = S_IDLE;
            end
         end
         default: begin
            state_in = S_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= S_IDLE;
         gain_ff      <= GAIN_RESET;
         alpha_ff     <= ALPHA_RESET;
         empty_ff     <= EMPTY_RESET;
         full_ff      <= FULL_RESET;
         smoothed_ff  <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         gain_ff      <= gain_in;
         alpha_ff     <= alpha_in;
         empty_ff     <= empty_in;
         full_ff      <= full_in;
         smoothed_ff  <= smoothed_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      rsp_mv_ff  <= rsp_mv_in;
      rsp_pct_ff <= rsp_pct_in;
   end

   assign req_ch.ready          = (state_ff == S_IDLE);
   assign rsp_ch.valid          = rsp_valid_ff;
   assign rsp_ch.voltage_mv     = rsp_mv_ff;
   assign rsp_ch.charge_percent = rsp_pct_ff;

`ifndef ASSERT_OFF
   a_pct_range: assert property (@(posedge clock) disable iff (reset)
      rsp_valid_ff |-> (rsp_pct_ff <= PCT_FULL))
      else $error("Charge estimate above one hundred percent.");

   a_mul_done_state: assert property (@(posedge clock) disable iff (reset)
      mul_done |-> (state_ff == S_MUL))
      else $error("Multiplier finished outside its sequencer step.");

   a_div_done_state: assert property (@(posedge clock) disable iff (reset)
      div_done |-> (state_ff == S_DIV))
      else $error("Divider finished outside its sequencer step.");

   a_smooth_hold: assert property (@(posedge clock) disable iff (reset)
      !ema_done |=> $stable(smoothed_ff))
      else $error("Smoothed voltage changed without a finished average.");

   a_out_stall: assert property (@(posedge clock) disable iff (reset)
      (state_ff == S_OUT && rsp_valid_ff && !rsp_ch.ready) |=> (state_ff == S_OUT))
      else $error("Result left the sequencer while the output stage was full.");
`endif

endmodule
